/* design/sttq_pkg.sv */
package sttq_pkg;

    // command codes carried in s_tuser
    localparam logic [1:0] CMD_ADD      = 2'd0;
    localparam logic [1:0] CMD_TICK     = 2'd1;
    localparam logic [1:0] CMD_DISPATCH = 2'd2;

    // status codes carried in m_tuser
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_NONE    = 2'd2;

    localparam int unsigned ID_W      = 8;
    localparam int unsigned DUE_W     = 32;
    localparam int unsigned PERIOD_W  = 22;
    localparam int unsigned PEND_W    = 8;
    localparam int unsigned MS_W      = 24;

    // most tasks run by one dispatch request
    localparam int unsigned MAX_RUN   = 16;
    localparam int unsigned RUN_CNT_W = 5;

    localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;
    localparam logic [PEND_W-1:0]   PEND_MAX   = '1;
    localparam logic [DUE_W-1:0]    DUE_MAX    = '1;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [DUE_W-1:0]    due;
        logic [PERIOD_W-1:0] period;
        logic [PEND_W-1:0]   pending;
    } entry_t;

endpackage

/* design/sttq_ram.sv */
module sttq_ram #(
    parameter int unsigned WIDTH = 70,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/sttq_div.sv */
module sttq_div #(
    parameter int unsigned N       = 24,
    parameter int unsigned DIVISOR = 10
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [N-1:0] dividend,
    output logic         done,
    output logic [N-1:0] quotient
);

    // floor(x / DIVISOR) = (x * ceil(2^SH / DIVISOR)) >> SH for any N-bit x
    localparam int unsigned     SH      = N + $clog2(DIVISOR);
    localparam int unsigned     PW      = SH + N;
    localparam longint unsigned RECIP_L = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1)
                                          / 64'(DIVISOR);
    localparam logic [PW-1:0]   RECIP   = PW'(RECIP_L);

    logic [PW-1:0] prod;
    logic [N-1:0]  quo_reg, quo_next;
    logic          done_reg, done_next;

    // multiply by the rounded-up reciprocal; quotient and done are registered on start
    assign prod = PW'(dividend) * RECIP;

    always_comb begin
        quo_next  = quo_reg;
        done_next = start;
        if (start) begin
            quo_next = prod[PW-1:SH];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* design/sorted_task_timer_queue.sv */
// Channel  Direction  Ports                      Contents
// s_       in         s_tvalid/s_tready          tuser=cmd, tdata=task_id,delay,period
// m_       out        m_tvalid/m_tready/m_tlast  tuser=run_valid,status, tdata=run_task
//
// One request at a time. Add: the two tick divisions (reciprocal multiply), then a
// read and a write per entry walked by the sorted insert. Tick: a read and a
// write per due head entry. Dispatch: per task run, a read and a write per
// entry shifted on pop plus the reinsert walk; each step is one read-modify-
// write of the entry RAM. Reset is synchronous and needs no clearing pass.
// A stalled m_ side holds the result and stops the sequencer until it drains.
module sorted_task_timer_queue #(
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned TICK_MS     = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // task_id[7:0], delay_ms[31:8], period_ms[55:32]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // run_task[7:0]
    output logic [2:0]  m_tuser,   // run_valid[0], status[2:1]
    output logic        m_tlast
);

    localparam int unsigned IW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned EW = $bits(sttq_pkg::entry_t);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DIV    = 4'd1;
    localparam logic [3:0] ST_INS_RD = 4'd2;
    localparam logic [3:0] ST_INS_WR = 4'd3;
    localparam logic [3:0] ST_TCK_RD = 4'd4;
    localparam logic [3:0] ST_TCK_WR = 4'd5;
    localparam logic [3:0] ST_DSP_RD = 4'd6;
    localparam logic [3:0] ST_DSP_CK = 4'd7;
    localparam logic [3:0] ST_POP_RD = 4'd8;
    localparam logic [3:0] ST_POP_WR = 4'd9;
    localparam logic [3:0] ST_EMIT   = 4'd10;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   now_reg, now_next;
    logic [CW-1:0] j_reg, j_next;
    logic [sttq_pkg::RUN_CNT_W-1:0] n_reg, n_next;
    logic          dsp_reg, dsp_next;
    logic          held_reg, held_next;
    logic [7:0]    held_id_reg, held_id_next;
    sttq_pkg::entry_t new_reg, new_next;
    logic [7:0]    res_id_reg, res_id_next;
    logic          res_vld_reg, res_vld_next;
    logic [1:0]    res_stat_reg, res_stat_next;
    logic          res_last_reg, res_last_next;

    logic          m_tvalid_reg, m_tvalid_next;
    logic [7:0]    m_id_reg;
    logic          m_vld_reg;
    logic [1:0]    m_stat_reg;
    logic          m_last_reg;

    logic          out_free, out_load;
    logic [7:0]    out_id;
    logic          out_vld, out_last;
    logic [1:0]    out_stat;

    logic          we, re;
    logic [IW-1:0] waddr, raddr;
    sttq_pkg::entry_t wentry, rentry;
    logic [EW-1:0] rdata;

    logic          div_start, div_done_d, div_done_p;
    logic [23:0]   q_delay, q_period;
    logic [32:0]   sum_add, sum_re;

    assign rentry = sttq_pkg::entry_t'(rdata);

    sttq_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ram (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(EW'(wentry)),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    sttq_div #(.N(sttq_pkg::MS_W), .DIVISOR(TICK_MS)) u_div_delay (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(s_tdata[31:8]),
        .done    (div_done_d),
        .quotient(q_delay)
    );

    sttq_div #(.N(sttq_pkg::MS_W), .DIVISOR(TICK_MS)) u_div_period (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(s_tdata[55:32]),
        .done    (div_done_p),
        .quotient(q_period)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign sum_add  = {1'b0, now_reg} + {9'd0, q_delay};
    assign sum_re   = {1'b0, rentry.due} + {11'd0, rentry.period};

    // sequencer: one RAM read, then its write-back, per step
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        now_next      = now_reg;
        j_next        = j_reg;
        n_next        = n_reg;
        dsp_next      = dsp_reg;
        held_next     = held_reg;
        held_id_next  = held_id_reg;
        new_next      = new_reg;
        res_id_next   = res_id_reg;
        res_vld_next  = res_vld_reg;
        res_stat_next = res_stat_reg;
        res_last_next = res_last_reg;
        out_load      = 1'b0;
        out_id        = res_id_reg;
        out_vld       = res_vld_reg;
        out_stat      = res_stat_reg;
        out_last      = res_last_reg;
        we            = 1'b0;
        waddr         = j_reg[IW-1:0];
        wentry        = new_reg;
        re            = 1'b0;
        raddr         = j_reg[IW-1:0];
        div_start     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                res_id_next   = '0;
                res_vld_next  = 1'b0;
                res_stat_next = sttq_pkg::STAT_OK;
                res_last_next = 1'b1;
                if (s_tvalid) begin
                    unique case (s_tuser)
                        sttq_pkg::CMD_ADD: begin
                            if (count_reg >= DEPTH_C) begin
                                res_stat_next = sttq_pkg::STAT_FULL;
                                state_next    = ST_EMIT;
                            end else begin
                                div_start      = 1'b1;
                                new_next.id    = s_tdata[7:0];
                                dsp_next       = 1'b0;
                                state_next     = ST_DIV;
                            end
                        end
                        sttq_pkg::CMD_TICK: begin
                            j_next     = '0;
                            state_next = ST_TCK_RD;
                        end
                        sttq_pkg::CMD_DISPATCH: begin
                            n_next     = '0;
                            held_next  = 1'b0;
                            dsp_next   = 1'b1;
                            state_next = ST_DSP_RD;
                        end
                        default: begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (div_done_d && div_done_p) begin
                    new_next.due     = sum_add[32] ? sttq_pkg::DUE_MAX : sum_add[31:0];
                    new_next.period  = (q_period[23:22] != 2'b00) ? sttq_pkg::PERIOD_MAX
                                                                   : q_period[21:0];
                    new_next.pending = '0;
                    j_next           = count_reg;
                    state_next       = ST_INS_RD;
                end
            end
            ST_INS_RD: begin
                if (j_reg == '0) begin
                    we         = 1'b1;
                    waddr      = '0;
                    count_next = count_reg + 1'b1;
                    state_next = dsp_reg ? ST_DSP_RD : ST_EMIT;
                end else begin
                    re         = 1'b1;
                    raddr      = IW'(j_reg - 1'b1);
                    state_next = ST_INS_WR;
                end
            end
            ST_INS_WR: begin
                we = 1'b1;
                if (rentry.due > new_reg.due) begin
                    wentry     = rentry;
                    j_next     = j_reg - 1'b1;
                    state_next = ST_INS_RD;
                end else begin
                    count_next = count_reg + 1'b1;
                    state_next = dsp_reg ? ST_DSP_RD : ST_EMIT;
                end
            end
            ST_TCK_RD: begin
                if (j_reg < count_reg) begin
                    re         = 1'b1;
                    state_next = ST_TCK_WR;
                end else begin
                    if (now_reg != sttq_pkg::DUE_MAX) now_next = now_reg + 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_TCK_WR: begin
                if (rentry.due <= now_reg) begin
                    we     = 1'b1;
                    wentry = rentry;
                    if (rentry.pending != sttq_pkg::PEND_MAX) begin
                        wentry.pending = rentry.pending + 1'b1;
                    end
                    j_next     = j_reg + 1'b1;
                    state_next = ST_TCK_RD;
                end else begin
                    if (now_reg != sttq_pkg::DUE_MAX) now_next = now_reg + 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_DSP_RD: begin
                if (count_reg != '0 &&
                    n_reg != sttq_pkg::RUN_CNT_W'(sttq_pkg::MAX_RUN)) begin
                    re         = 1'b1;
                    raddr      = '0;
                    state_next = ST_DSP_CK;
                end else begin
                    res_id_next   = held_id_reg;
                    res_vld_next  = held_reg;
                    res_stat_next = held_reg ? sttq_pkg::STAT_OK : sttq_pkg::STAT_NONE;
                    state_next    = ST_EMIT;
                end
            end
            ST_DSP_CK: begin
                if (rentry.pending == '0) begin
                    res_id_next   = held_id_reg;
                    res_vld_next  = held_reg;
                    res_stat_next = held_reg ? sttq_pkg::STAT_OK : sttq_pkg::STAT_NONE;
                    state_next    = ST_EMIT;
                end else if (!held_reg || out_free) begin
                    // flush the previous run, known now not to be the last
                    out_load         = held_reg;
                    out_id           = held_id_reg;
                    out_vld          = 1'b1;
                    out_stat         = sttq_pkg::STAT_OK;
                    out_last         = 1'b0;
                    held_next        = 1'b1;
                    held_id_next     = rentry.id;
                    new_next.id      = rentry.id;
                    new_next.due     = sum_re[32] ? sttq_pkg::DUE_MAX : sum_re[31:0];
                    new_next.period  = rentry.period;
                    new_next.pending = '0;
                    n_next           = n_reg + 1'b1;
                    j_next           = '0;
                    state_next       = ST_POP_RD;
                end
            end
            ST_POP_RD: begin
                if (j_reg + 1'b1 < count_reg) begin
                    re         = 1'b1;
                    raddr      = IW'(j_reg + 1'b1);
                    state_next = ST_POP_WR;
                end else begin
                    count_next = count_reg - 1'b1;
                    j_next     = count_reg - 1'b1;
                    state_next = ST_INS_RD;
                end
            end
            ST_POP_WR: begin
                we         = 1'b1;
                wentry     = rentry;
                j_next     = j_reg + 1'b1;
                state_next = ST_POP_RD;
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // hold the result until the m_ side takes it
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            now_reg      <= '0;
            j_reg        <= '0;
            n_reg        <= '0;
            dsp_reg      <= 1'b0;
            held_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            now_reg      <= now_next;
            j_reg        <= j_next;
            n_reg        <= n_next;
            dsp_reg      <= dsp_next;
            held_reg     <= held_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        held_id_reg  <= held_id_next;
        new_reg      <= new_next;
        res_id_reg   <= res_id_next;
        res_vld_reg  <= res_vld_next;
        res_stat_reg <= res_stat_next;
        res_last_reg <= res_last_next;
        if (out_load) begin
            m_id_reg   <= out_vld ? out_id : '0;
            m_vld_reg  <= out_vld;
            m_stat_reg <= out_stat;
            m_last_reg <= out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_id_reg;
    assign m_tuser  = {m_stat_reg, m_vld_reg};
    assign m_tlast  = m_last_reg;

endmodule

/* design/sttq_check.sv */
module sttq_check (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [2:0] m_tuser,
    input logic       m_tlast
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // one request at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // a task run carries status ok, otherwise no id and end of the request
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tuser[2:1] == sttq_pkg::STAT_OK)
        else $error("run with bad status");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0 && m_tlast)
        else $error("non-run result malformed");

endmodule

bind sorted_task_timer_queue sttq_check u_sttq_check (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
);
